// ===== design/hpt_pkg.sv =====
// Package for the hashed page table: table geometry, codes and the
// controller/datapath interface structs. No dependencies.
package hpt_pkg;

  // Table size must be a power of two; the home slot is a bit-select.
  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PAGE_W     = 20;
  localparam int FRAME_W    = 20;
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 2;
  localparam int SLOT_W     = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_CHECK = 3'b100
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;    // capture request, set home slot
    logic rd;      // read page/frame memory at current slot
    logic step;    // advance to next slot
    logic finish;  // retire request into output register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic hit;       // lookup/delete matched an occupied slot
    logic free;      // insert found empty or deleted slot
    logic miss;      // lookup/delete hit empty slot, or unused kind
    logic last;      // current probe is the final one
    logic out_busy;  // output register holds a beat that is not taken
  } dp_sts_t;

endpackage

// ===== design/hpt_ctrl.sv =====
// Probe sequencer for the hashed page table.
// Depends on hpt_pkg.
module hpt_ctrl import hpt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   done;

  assign done = sts_i.hit || sts_i.free || sts_i.miss || sts_i.last;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        // wait here while the previous result is still not taken
        if (!sts_i.out_busy) begin
          if (done) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/hpt_dp.sv =====
// Datapath for the hashed page table: request registers, slot state flops,
// page/frame memory and the output register. Depends on hpt_pkg.
module hpt_dp import hpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [PAGE_W-1:0]  page_number_i,
  input  logic [FRAME_W-1:0] frame_number_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [FRAME_W-1:0] found_frame_o,
  output logic [SLOT_W-1:0]  slot_index_o
);

  logic [KIND_W-1:0]  kind_q;
  logic [PAGE_W-1:0]  page_q;
  logic [FRAME_W-1:0] frame_q;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;

  // page in upper half, frame in lower half
  logic [PAGE_W+FRAME_W-1:0] mem_q [TABLE_SIZE];
  logic [PAGE_W+FRAME_W-1:0] rd_q;
  slot_e                     slot_st_q [TABLE_SIZE];

  logic               out_valid_q;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [FRAME_W-1:0] frame_out_q, frame_out_d;
  logic [SLOT_W-1:0]  slot_out_q, slot_out_d;

  slot_e cur_st;
  logic  used, is_ld, is_ins, match;
  logic  hit, free, miss, last;

  assign cur_st = slot_st_q[idx_q];
  // code three counts as occupied
  assign used   = (cur_st != SLOT_EMPTY) && (cur_st != SLOT_DELETED);
  assign is_ld  = (kind_q == KIND_LOOKUP) || (kind_q == KIND_DELETE);
  assign is_ins = (kind_q == KIND_INSERT);
  assign match  = (rd_q[PAGE_W+FRAME_W-1:FRAME_W] == page_q);

  assign hit  = is_ld && used && match;
  assign free = is_ins && !used;
  assign miss = (!is_ld && !is_ins) || (is_ld && (cur_st == SLOT_EMPTY));
  assign last = (cnt_q == IDX_W'(TABLE_SIZE - 1));

  assign sts_o.hit      = hit;
  assign sts_o.free     = free;
  assign sts_o.miss     = miss;
  assign sts_o.last     = last;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  always_comb begin
    idx_d = idx_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      idx_d = page_number_i[IDX_W-1:0];
      cnt_d = '0;
    end else if (cmd_i.step) begin
      idx_d = (idx_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    if (hit) begin
      status_d    = ST_OK;
      frame_out_d = rd_q[FRAME_W-1:0];
      slot_out_d  = SLOT_W'(idx_q);
    end else if (free) begin
      status_d    = ST_OK;
      frame_out_d = frame_q;
      slot_out_d  = SLOT_W'(idx_q);
    end else begin
      status_d    = is_ins ? ST_FULL : ST_NOT_FOUND;
      frame_out_d = '0;
      slot_out_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      page_q  <= page_number_i;
      frame_q <= frame_number_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem_q[idx_q];
    end
    if (cmd_i.finish && free) begin
      mem_q[idx_q] <= {page_q, frame_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_st_q[i] <= SLOT_EMPTY;
      end
    end else if (cmd_i.finish) begin
      if (free) begin
        slot_st_q[idx_q] <= SLOT_USED;
      end else if (hit && (kind_q == KIND_DELETE)) begin
        slot_st_q[idx_q] <= SLOT_DELETED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q    <= status_d;
      frame_out_q <= frame_out_d;
      slot_out_q  <= slot_out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_frame_o = frame_out_q;
  assign slot_index_o  = slot_out_q;

endmodule

// ===== design/hashed_page_table_linear_probe.sv =====
// Channel  Handshake                Payload
// in       in_valid_i / in_stall_o  kind_i, page_number_i, frame_number_i
// out      out_valid_o / out_stall_i status_o, found_frame_o, slot_index_o
//
// One request at a time: the request is accepted, then each probed slot takes
// a memory read, then a compare, from the home slot up to TABLE_SIZE slots at
// worst. The registered page/frame memory read is why each probe has a read
// state before its compare.
// Reset empties every slot at once; no clearing pass.
// A finished beat waits in the output register; a new request is accepted
// meanwhile and its first compare holds until that beat is taken.
// Top level of the hashed page table. Depends on hpt_pkg, hpt_ctrl, hpt_dp.
module hashed_page_table_linear_probe import hpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [PAGE_W-1:0]  page_number_i,
  input  logic [FRAME_W-1:0] frame_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [FRAME_W-1:0] found_frame_o,
  output logic [SLOT_W-1:0]  slot_index_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .page_number_i  (page_number_i),
    .frame_number_i (frame_number_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .found_frame_o  (found_frame_o),
    .slot_index_o   (slot_index_o)
  );

endmodule

// ===== design/hpt_checker.sv =====
// Port-level checks for the hashed page table, bound to the top level.
// Depends on hpt_pkg and hashed_page_table_linear_probe.
module hpt_checker import hpt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [KIND_W-1:0]  kind_i,
  input logic [PAGE_W-1:0]  page_number_i,
  input logic [FRAME_W-1:0] frame_number_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [STAT_W-1:0]  status_o,
  input logic [FRAME_W-1:0] found_frame_o,
  input logic [SLOT_W-1:0]  slot_index_o
);

  // a stalled output beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // one request in flight: stall rises right after an accepted beat
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request accepted while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_NOT_FOUND ||
                     status_o == ST_FULL))
    else $error("illegal status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (found_frame_o == '0 && slot_index_o == '0))
    else $error("failed request carries frame or slot");

  // shortest request is accept, read, compare
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result earlier than one probe");

endmodule

bind hashed_page_table_linear_probe hpt_checker u_hpt_checker (.*);

// ===== tb/sv/hashed_page_table_linear_probe_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for hashed_page_table_linear_probe: a clocked driver and
// monitor, a page-table predictor and a results scoreboard. Depends on hpt_pkg and the DUT.
module hashed_page_table_linear_probe_tb;
  import hpt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 2 * TABLE_SIZE + 8;
  localparam int PHASE_ITEMS    = 350;
  localparam int SWING_ITEMS    = 150;  // fill/drain swing length inside a phase

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame;
    logic [SLOT_W-1:0]  slot;
  } answer_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [KIND_W-1:0]  kind_i = '0;
  logic [PAGE_W-1:0]  page_number_i = '0;
  logic [FRAME_W-1:0] frame_number_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [STAT_W-1:0]  status_o;
  logic [FRAME_W-1:0] found_frame_o;
  logic [SLOT_W-1:0]  slot_index_o;

  hashed_page_table_linear_probe DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .page_number_i  (page_number_i),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_frame_o  (found_frame_o),
    .slot_index_o   (slot_index_o)
  );

  // Predicted page table
  slot_e              tbl_state [TABLE_SIZE];
  logic [PAGE_W-1:0]  tbl_page  [TABLE_SIZE];
  logic [FRAME_W-1:0] tbl_frame [TABLE_SIZE];

  request_t           req_q[$];
  answer_t            answers_q[$];
  logic [PAGE_W-1:0]  known_pages[$];

  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       n_errors = 0;
  int       n_results = 0;
  int       n_kind [4] = '{default: 0};
  int       n_status [4] = '{default: 0};
  int       quiet_cycles = 0;
  logic     beat_seen = 1'b0;
  answer_t  beat_ans;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Applies one request to the predicted table and returns the answer it yields.
  function automatic answer_t pt_apply(request_t rq);
    answer_t a;
    int      idx;
    bit      done;
    a.status = ST_NOT_FOUND;
    a.frame  = '0;
    a.slot   = '0;
    idx      = int'(rq.page % TABLE_SIZE);
    done     = 1'b0;
    if (rq.kind == KIND_LOOKUP || rq.kind == KIND_DELETE) begin
      for (int n = 0; n < TABLE_SIZE && !done; n++) begin
        if (tbl_state[idx] == SLOT_EMPTY) begin
          done = 1'b1;
        end else if (tbl_state[idx] != SLOT_DELETED && tbl_page[idx] == rq.page) begin
          a.status = ST_OK;
          a.frame  = tbl_frame[idx];
          a.slot   = idx[SLOT_W-1:0];
          if (rq.kind == KIND_DELETE) tbl_state[idx] = SLOT_DELETED;
          done = 1'b1;
        end
        idx = (idx + 1) % TABLE_SIZE;
      end
    end else if (rq.kind == KIND_INSERT) begin
      a.status = ST_FULL;
      for (int n = 0; n < TABLE_SIZE && !done; n++) begin
        if (tbl_state[idx] == SLOT_EMPTY || tbl_state[idx] == SLOT_DELETED) begin
          tbl_state[idx] = SLOT_USED;
          tbl_page[idx]  = rq.page;
          tbl_frame[idx] = rq.frame;
          a.status = ST_OK;
          a.frame  = rq.frame;
          a.slot   = idx[SLOT_W-1:0];
          done = 1'b1;
        end
        idx = (idx + 1) % TABLE_SIZE;
      end
    end
    return a;
  endfunction

  function automatic void queue_request(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] page,
                                        logic [FRAME_W-1:0] frame);
    request_t r;
    r.kind  = kind;
    r.page  = page;
    r.frame = frame;
    req_q.push_back(r);
    if (kind == KIND_INSERT) begin
      known_pages.push_back(page);
      if (known_pages.size() > 96) void'(known_pages.pop_front());
    end
  endfunction

  // Fresh keys: half fully random, half clustered near slot 0 or the top of the table
  // so that chains collide and wrap around.
  function automatic logic [PAGE_W-1:0] fresh_page();
    logic [PAGE_W-1:0] p;
    p = PAGE_W'($urandom);
    case ($urandom_range(0, 3))
      2: p[IDX_W-1:0] = IDX_W'($urandom_range(0, 3));
      3: p[IDX_W-1:0] = IDX_W'($urandom_range(TABLE_SIZE - 4, TABLE_SIZE - 1));
      default: ;
    endcase
    return p;
  endfunction

  function automatic void queue_random(bit filling);
    int                 r;
    logic [KIND_W-1:0]  kind;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    bit                 reuse;
    r = $urandom_range(0, 99);
    if (r < 3)                       kind = KIND_UNUSED;
    else if (r < (filling ? 78 : 18)) kind = KIND_INSERT;
    else if (r < (filling ? 93 : 48)) kind = KIND_LOOKUP;
    else                              kind = KIND_DELETE;
    case ($urandom_range(0, 3))
      0:       frame = '0;
      1:       frame = '1;
      default: frame = FRAME_W'($urandom);
    endcase
    reuse = known_pages.size() > 0 &&
            $urandom_range(0, 99) < (kind == KIND_INSERT ? 15 : 80);
    page = reuse ? known_pages[$urandom_range(0, known_pages.size() - 1)] : fresh_page();
    queue_request(kind, page, frame);
  endfunction

  // Driver: hold a beat until taken, then maybe idle before the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        nxt.kind  = kind_i;
        nxt.page  = page_number_i;
        nxt.frame = frame_number_i;
        answers_q.push_back(pt_apply(nxt));
        n_kind[kind_i]++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = req_q.pop_front();
          in_valid_i     <= 1'b1;
          kind_i         <= nxt.kind;
          page_number_i  <= nxt.page;
          frame_number_i <= nxt.frame;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, latch each taken beat for the checker.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      beat_seen   <= 1'b0;
    end else begin
      beat_seen   <= out_valid_o && !out_stall_i;
      beat_ans    <= {status_o, found_frame_o, slot_index_o};
      out_stall_i <= $urandom_range(0, 99) < recv_idle_pct;
    end
  end

  // Checked on the falling edge so every prediction of that rising edge is already queued.
  always @(negedge clk_i) begin
    answer_t want;
    if (beat_seen) begin
      n_results++;
      n_status[beat_ans.status]++;
      if (answers_q.size() == 0) begin
        if (n_errors < 10)
          $display("[%0t] unexpected beat: status %0d frame %05h slot %0d", $realtime,
                   beat_ans.status, beat_ans.frame, beat_ans.slot);
        n_errors++;
      end else begin
        want = answers_q.pop_front();
        if (want.status != beat_ans.status || want.frame != beat_ans.frame ||
            want.slot != beat_ans.slot) begin
          if (n_errors < 10)
            $display("[%0t] beat %0d: expected status %0d frame %05h slot %0d, got %0d %05h %0d",
                     $realtime, n_results, want.status, want.frame, want.slot,
                     beat_ans.status, beat_ans.frame, beat_ans.slot);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
          $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int n_random;
    for (int i = 0; i < TABLE_SIZE; i++) tbl_state[i] = SLOT_EMPTY;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk_i);
      case (phase)
        0: begin send_idle_pct = 21; recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      n_random = PHASE_ITEMS;
      if (phase == 0) begin
        queue_request(KIND_LOOKUP, 20'h00000, 20'h00000);  // empty table
        queue_request(KIND_DELETE, 20'h00005, 20'hFFFFF);
        queue_request(KIND_INSERT, 20'h00000, 20'hFFFFF);
        queue_request(KIND_INSERT, 20'hFFFFF, 20'h00000);  // top slot
        queue_request(KIND_INSERT, 20'h00040, 20'h12345);  // collides at slot 0
        queue_request(KIND_INSERT, 20'h0007F, 20'hABCDE);  // wraps past the end
        queue_request(KIND_LOOKUP, 20'h0007F, 20'h00000);
        queue_request(KIND_LOOKUP, 20'h00040, 20'h00000);
        queue_request(KIND_DELETE, 20'h00040, 20'h00000);
        queue_request(KIND_LOOKUP, 20'h0007F, 20'h00000);  // skips a deleted slot
        queue_request(KIND_LOOKUP, 20'h00040, 20'h00000);  // gone
        queue_request(KIND_INSERT, 20'h00080, 20'h55555);  // reuses the deleted slot
        queue_request(KIND_INSERT, 20'h00000, 20'h00001);  // duplicate key
        queue_request(KIND_LOOKUP, 20'h00000, 20'h00000);
        queue_request(KIND_DELETE, 20'h00000, 20'h00000);
        queue_request(KIND_LOOKUP, 20'h00000, 20'h00000);  // finds the duplicate
        queue_request(KIND_UNUSED, 20'hFFFFF, 20'hFFFFF);
        queue_request(KIND_LOOKUP, 20'hFFFFF, 20'h00000);
        queue_request(KIND_DELETE, 20'hFFFFF, 20'h00000);
        queue_request(KIND_DELETE, 20'hFFFFF, 20'h00000);
        queue_request(KIND_UNUSED, 20'h00000, 20'h00000);
        queue_request(KIND_INSERT, 20'hAAAAA, 20'h55555);
        queue_request(KIND_INSERT, 20'h55555, 20'hAAAAA);
        queue_request(KIND_LOOKUP, 20'hAAAAA, 20'h00000);
        queue_request(KIND_DELETE, 20'h55555, 20'h00000);
        n_random = PHASE_ITEMS - 25;
      end
      // Fill swings favour inserts to drive the table toward full; drain swings favour deletes.
      for (int k = 0; k < n_random; k++) queue_random(((k / SWING_ITEMS) % 2) == 0);
      while (req_q.size() != 0 || in_valid_i || answers_q.size() != 0 || beat_seen)
        @(negedge clk_i);
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Covered %0d lookups, %0d inserts, %0d deletes, %0d unused-kind requests",
             n_kind[KIND_LOOKUP], n_kind[KIND_INSERT], n_kind[KIND_DELETE],
             n_kind[KIND_UNUSED]);
    $display("%0d results: %0d ok, %0d not found, %0d table full; %0d mismatches",
             n_results, n_status[ST_OK], n_status[ST_NOT_FOUND], n_status[ST_FULL], n_errors);
    if (n_errors == 0 && answers_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hpt_pkg.sv
design/hpt_ctrl.sv
design/hpt_dp.sv
design/hashed_page_table_linear_probe.sv
design/hpt_checker.sv
tb/sv/hashed_page_table_linear_probe_tb.sv
